>>> hdl/bare_pkg.sv
package bare_pkg;

	localparam int SAMPLE_W = 24;
	localparam int CFG_W = 16;
	localparam int INDEX_W = 16;
	localparam int MEAN_W = 24;
	localparam int ERR_W = 24;
	localparam int WORD_W = 64;
	localparam int CFG_INDEX_W = 1;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [CFG_W-1:0] BLOCK_LENGTH_RST = 16'd1000;
	localparam logic [CFG_W-1:0] BLOCKS_WANTED_RST = 16'd100;

	localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_LENGTH = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCKS_WANTED = 1'd1;

	typedef enum logic [1:0] {
		OP_DIV,
		OP_MUL,
		OP_SQRT
	} arith_op_t;

	typedef struct packed {
		logic start;
		arith_op_t op;
	} arith_req_t;

	typedef struct packed {
		logic done;
		logic rem_nz;
	} arith_rsp_t;

endpackage

>>> hdl/bare_in_if.sv
interface bare_in_if import bare_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic restart;

	modport source(output valid, output sample, output restart, input ready);
	modport sink(input valid, input sample, input restart, output ready);
endinterface

>>> hdl/bare_out_if.sv
interface bare_out_if import bare_pkg::*; ();
	logic valid;
	logic ready;
	logic [INDEX_W-1:0] block_index;
	logic signed [MEAN_W-1:0] running_mean;
	logic [ERR_W-1:0] running_error;
	logic final_block;

	modport source(output valid, output block_index, output running_mean,
		output running_error, output final_block, input ready);
	modport sink(input valid, input block_index, input running_mean,
		input running_error, input final_block, output ready);
endinterface

>>> hdl/bare_arith.sv
module bare_arith import bare_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  arith_req_t        req,
	input  logic [WORD_W-1:0] a,
	input  logic [WORD_W-1:0] b,
	output arith_rsp_t        rsp,
	output logic [WORD_W-1:0] res
);

	localparam int CNT_W = $clog2(WORD_W) + 1;
	localparam int ROOT_W = WORD_W / 2;

	logic busy_q;
	logic done_q;
	arith_op_t op_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] sh_q;
	logic [WORD_W-1:0] b_q;
	logic [ROOT_W-1:0] root_q;

	logic [WORD_W:0] opa;
	logic [WORD_W:0] opb;
	logic sub;
	logic [WORD_W+1:0] sum;
	logic ge;

	// one shared add/subtract, operands steered by the running operation
	always_comb begin
		case (op_q)
			OP_DIV: begin
				opa = {acc_q, sh_q[WORD_W-1]};
				opb = {1'b0, b_q};
				sub = 1'b1;
			end
			OP_SQRT: begin
				opa = {acc_q[WORD_W-2:0], sh_q[WORD_W-1 -: 2]};
				opb = {(ROOT_W - 1)'(0), root_q, 2'b01};
				sub = 1'b1;
			end
			OP_MUL: begin
				opa = {acc_q, 1'b0};
				opb = {1'b0, (sh_q[WORD_W-1] ? b_q : WORD_W'(0))};
				sub = 1'b0;
			end
			default: begin
				opa = '0;
				opb = '0;
				sub = 1'b0;
			end
		endcase
		sum = {1'b0, opa} + (sub ? ~{1'b0, opb} : {1'b0, opb}) + (WORD_W + 2)'(sub);
		ge = !sum[WORD_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q <= OP_DIV;
			cnt_q <= '0;
			acc_q <= '0;
			sh_q <= '0;
			b_q <= '0;
			root_q <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				op_q <= req.op;
				acc_q <= '0;
				sh_q <= a;
				b_q <= b;
				root_q <= '0;
				cnt_q <= (req.op == OP_SQRT) ? CNT_W'(ROOT_W) : CNT_W'(WORD_W);
			end else if (busy_q) begin
				case (op_q)
					OP_DIV: begin
						acc_q <= ge ? sum[WORD_W-1:0] : opa[WORD_W-1:0];
						sh_q <= {sh_q[WORD_W-2:0], ge};
					end
					OP_SQRT: begin
						acc_q <= ge ? sum[WORD_W-1:0] : opa[WORD_W-1:0];
						sh_q <= {sh_q[WORD_W-3:0], 2'b00};
						root_q <= {root_q[ROOT_W-2:0], ge};
					end
					OP_MUL: begin
						acc_q <= sum[WORD_W-1:0];
						sh_q <= {sh_q[WORD_W-2:0], 1'b0};
					end
					default: begin
						acc_q <= acc_q;
					end
				endcase
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		rsp.rem_nz = (acc_q != '0);
		case (op_q)
			OP_DIV: res = sh_q;
			OP_MUL: res = acc_q;
			OP_SQRT: res = WORD_W'(root_q);
			default: res = '0;
		endcase
	end

endmodule

>>> hdl/block_average_running_error_core.sv
// Blocking-method running mean and statistical error over a sample stream.
// Input channel in_ch carries one signed Q8.16 sample per transfer, plus a
// restart flag that clears all totals before that sample counts.
// Output channel out_ch carries one result per completed block: block index,
// running mean (Q8.16) and its statistical error (unsigned Q8.16, 0 on the
// first block); final_block marks the last block of the run, after which
// samples are dropped until a restart.
// Configuration: cfg_we/cfg_index/cfg_data write block_length (index 0) and
// blocks_wanted (index 1); reset values 1000 and 100.
// Throughput: samples that do not close a block are taken one per cycle. A sample
// that closes a block runs the one-bit-per-cycle shared arithmetic unit (64
// steps per divide or multiply, 32 per square root): in_ch.ready stays low
// from that sample until the result is loaded into the output register, and
// out_ch.valid rises as in_ch.ready returns high.
// A held result does not block new samples; a block that finishes while the
// previous result is still stalled waits until out_ch.ready takes it.
// Reset clears all totals and counters and drops any pending result.
module block_average_running_error_core import bare_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	bare_in_if.sink                in_ch,
	bare_out_if.source             out_ch
);

	localparam int BSUM_W = SAMPLE_W + COUNT_BITS;
	localparam int SOM_W = BSUM_W + COUNT_BITS;
	localparam int K_W = COUNT_BITS + 1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MSTART,
		S_MDIV,
		S_MACC,
		S_MMUL,
		S_RSTART,
		S_RDIV,
		S_RMUL_START,
		S_RMUL,
		S_QDIV,
		S_VDIV,
		S_SQRT,
		S_DONE
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0] block_length_q;
	logic [CFG_W-1:0] blocks_wanted_q;

	logic [COUNT_BITS-1:0] sib_q;
	logic [COUNT_BITS-1:0] bd_q;
	logic signed [BSUM_W-1:0] bsum_q;
	logic signed [SOM_W-1:0] som_q;
	logic [WORD_W-1:0] sosm_q;
	logic neg_q;
	logic signed [BSUM_W-1:0] mean_q;
	logic signed [SOM_W-1:0] rmean_q;
	logic [WORD_W-1:0] rsq_q;
	logic [ERR_W-1:0] err_q;

	arith_req_t req_q;
	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] b_q;
	arith_rsp_t rsp;
	logic [WORD_W-1:0] arith_res;

	logic out_valid_q;
	logic [INDEX_W-1:0] out_index_q;
	logic signed [MEAN_W-1:0] out_mean_q;
	logic [ERR_W-1:0] out_err_q;
	logic out_final_q;

	logic [COUNT_BITS-1:0] len;
	logic [COUNT_BITS-1:0] want;
	logic in_xfer;
	logic out_xfer;
	logic out_load;
	logic arith_go;
	arith_op_t arith_op;
	logic signed [BSUM_W-1:0] bsum_eff;
	logic signed [BSUM_W-1:0] bsum_new;
	logic [COUNT_BITS-1:0] sib_eff;
	logic [COUNT_BITS-1:0] sib_new;
	logic [COUNT_BITS-1:0] bd_eff;
	logic [COUNT_BITS-1:0] bd_inc;
	logic run_over;
	logic complete;
	logic [K_W-1:0] k;
	logic [BSUM_W-1:0] bsum_mag;
	logic [BSUM_W-1:0] mean_mag;
	logic [SOM_W-1:0] som_mag;
	logic [SOM_W-1:0] rmean_mag;
	logic [WORD_W-1:0] q_fix;
	logic [WORD_W-1:0] var_w;

	bare_arith u_arith (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_q),
		.a     (a_q),
		.b     (b_q),
		.rsp   (rsp),
		.res   (arith_res)
	);

	always_comb begin
		len = block_length_q[COUNT_BITS-1:0];
		if (len == '0) begin
			len = COUNT_BITS'(1);
		end
		want = blocks_wanted_q[COUNT_BITS-1:0];
		if (want == '0) begin
			want = COUNT_BITS'(1);
		end
		in_xfer = in_ch.valid && in_ch.ready;
		out_xfer = out_valid_q && out_ch.ready;
		out_load = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);
		bsum_eff = in_ch.restart ? BSUM_W'(0) : bsum_q;
		sib_eff = in_ch.restart ? COUNT_BITS'(0) : sib_q;
		bd_eff = in_ch.restart ? COUNT_BITS'(0) : bd_q;
		bsum_new = bsum_eff + BSUM_W'(in_ch.sample);
		sib_new = sib_eff + COUNT_BITS'(1);
		run_over = (bd_eff >= want);
		complete = (sib_new == '0) || (sib_new >= len);
		bd_inc = bd_q + COUNT_BITS'(1);
		k = K_W'(bd_q) + K_W'(1);
		bsum_mag = bsum_q[BSUM_W-1] ? BSUM_W'(-bsum_q) : BSUM_W'(bsum_q);
		mean_mag = mean_q[BSUM_W-1] ? BSUM_W'(-mean_q) : BSUM_W'(mean_q);
		som_mag = som_q[SOM_W-1] ? SOM_W'(-som_q) : SOM_W'(som_q);
		rmean_mag = rmean_q[SOM_W-1] ? SOM_W'(-rmean_q) : SOM_W'(rmean_q);
		// floor toward minus infinity for a negative dividend
		q_fix = neg_q ? (rsp.rem_nz ? ~arith_res : WORD_W'(0) - arith_res) : arith_res;
		var_w = arith_res - rsq_q;
		arith_go = 1'b0;
		arith_op = OP_DIV;
		case (state_q)
			S_MSTART, S_RSTART: begin
				arith_go = 1'b1;
			end
			S_MACC, S_RMUL_START: begin
				arith_go = 1'b1;
				arith_op = OP_MUL;
			end
			S_RMUL, S_QDIV: begin
				arith_go = rsp.done;
			end
			S_VDIV: begin
				arith_go = rsp.done;
				arith_op = OP_SQRT;
			end
			default: begin
				arith_go = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			block_length_q <= BLOCK_LENGTH_RST;
			blocks_wanted_q <= BLOCKS_WANTED_RST;
			sib_q <= '0;
			bd_q <= '0;
			bsum_q <= '0;
			som_q <= '0;
			sosm_q <= '0;
			neg_q <= 1'b0;
			mean_q <= '0;
			rmean_q <= '0;
			rsq_q <= '0;
			err_q <= '0;
			req_q <= '{start: 1'b0, op: OP_DIV};
			a_q <= '0;
			b_q <= '0;
			out_valid_q <= 1'b0;
			out_index_q <= '0;
			out_mean_q <= '0;
			out_err_q <= '0;
			out_final_q <= 1'b0;
		end else begin
			req_q <= '{start: arith_go, op: arith_op};
			if (out_xfer && !out_load) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_BLOCK_LENGTH: block_length_q <= cfg_data;
					REG_BLOCKS_WANTED: blocks_wanted_q <= cfg_data;
					default: block_length_q <= block_length_q;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (in_ch.restart) begin
							som_q <= '0;
							sosm_q <= '0;
						end
						bd_q <= bd_eff;
						if (run_over) begin
							bsum_q <= bsum_eff;
							sib_q <= sib_eff;
						end else begin
							bsum_q <= bsum_new;
							sib_q <= complete ? COUNT_BITS'(0) : sib_new;
							if (complete) begin
								state_q <= S_MSTART;
							end
						end
					end
				end
				S_MSTART: begin
					a_q <= WORD_W'(bsum_mag);
					b_q <= WORD_W'(len);
					neg_q <= bsum_q[BSUM_W-1];
					bsum_q <= '0;
					state_q <= S_MDIV;
				end
				S_MDIV: begin
					if (rsp.done) begin
						mean_q <= q_fix[BSUM_W-1:0];
						state_q <= S_MACC;
					end
				end
				S_MACC: begin
					som_q <= som_q + SOM_W'(mean_q);
					a_q <= WORD_W'(mean_mag);
					b_q <= WORD_W'(mean_mag);
					state_q <= S_MMUL;
				end
				S_MMUL: begin
					if (rsp.done) begin
						sosm_q <= sosm_q + arith_res;
						state_q <= S_RSTART;
					end
				end
				S_RSTART: begin
					a_q <= WORD_W'(som_mag);
					b_q <= WORD_W'(k);
					neg_q <= som_q[SOM_W-1];
					state_q <= S_RDIV;
				end
				S_RDIV: begin
					if (rsp.done) begin
						rmean_q <= q_fix[SOM_W-1:0];
						if (bd_q == '0) begin
							err_q <= '0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_RMUL_START;
						end
					end
				end
				S_RMUL_START: begin
					a_q <= WORD_W'(rmean_mag);
					b_q <= WORD_W'(rmean_mag);
					state_q <= S_RMUL;
				end
				S_RMUL: begin
					if (rsp.done) begin
						rsq_q <= arith_res;
						a_q <= sosm_q;
						b_q <= WORD_W'(k);
						state_q <= S_QDIV;
					end
				end
				S_QDIV: begin
					if (rsp.done) begin
						// negative variance clamps to zero
						a_q <= var_w[WORD_W-1] ? WORD_W'(0) : var_w;
						b_q <= WORD_W'(bd_q);
						state_q <= S_VDIV;
					end
				end
				S_VDIV: begin
					if (rsp.done) begin
						a_q <= arith_res;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (rsp.done) begin
						err_q <= arith_res[ERR_W-1:0];
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_index_q <= INDEX_W'(bd_q);
						out_mean_q <= rmean_q[MEAN_W-1:0];
						out_err_q <= err_q;
						out_final_q <= (bd_inc >= want) || (bd_inc == '0);
						bd_q <= (bd_inc == '0) ? want : bd_inc;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.block_index = out_index_q;
	assign out_ch.running_mean = out_mean_q;
	assign out_ch.running_error = out_err_q;
	assign out_ch.final_block = out_final_q;

endmodule

>>> hdl/bare_checker.sv
module bare_checker import bare_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [INDEX_W-1:0]       block_index,
	input logic signed [MEAN_W-1:0] running_mean,
	input logic [ERR_W-1:0]         running_error,
	input logic                     final_block
);

	// stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(block_index) && $stable(running_mean)
			&& $stable(running_error) && $stable(final_block))
		else $error("result payload changed while stalled");

	// a new result only appears after a block computation, with input held off
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without a block computation");

	// the first block of a run has no error estimate
	a_first_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && block_index == '0 |-> running_error == '0)
		else $error("nonzero error on first block");

endmodule

bind block_average_running_error_core bare_checker u_bare_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.block_index  (out_ch.block_index),
	.running_mean (out_ch.running_mean),
	.running_error(out_ch.running_error),
	.final_block  (out_ch.final_block)
);
